// ===== rtl/glk_pkg.sv =====
`default_nettype none
package glk_pkg;

  // Defaults for the top-level parameters.
  localparam int MAX_TAPS_DEF     = 64;
  localparam int TABLE_POINTS_DEF = 1024;
  localparam int STD_RANGE_DEF    = 8;

  // Fixed field widths.
  localparam int X_W    = 24;
  localparam int INV_W  = 24;
  localparam int NT_W   = 7;
  localparam int VAL_W  = 32;
  localparam int TIDX_W = 6;
  localparam int ABS_W  = 25;

  // Shared multiplier operand widths.
  localparam int MA_W = 40;
  localparam int MB_W = 32;
  localparam int MP_W = MA_W + MB_W;

  // Shared divider widths: the dividend covers 2^62, the divisor the tap sum.
  localparam int DVD_W  = 63;
  localparam int DVS_W  = 40;
  localparam int DCNT_W = 6;

  // Table build constants.
  localparam longint unsigned Q30_ONE      = 64'd1 << 30;
  localparam longint unsigned INV_SQRT_2PI = 64'd1713444047;
  localparam int              SERIES_TERMS = 14;
  localparam longint unsigned EXP_CUTOFF   = 64'd24;

  // Request to the divider.
  typedef struct packed {
    logic              start;
    logic [DCNT_W-1:0] count;
  } div_req_t;

  // Unsigned quotient by restoring shift and subtract, used while the table is built.
  function automatic longint unsigned udiv(input longint unsigned a,
                                           input longint unsigned b);
    longint unsigned q;
    longint unsigned r;
    q = 0;
    r = 0;
    for (int k = 63; k >= 0; k--) begin
      r = {r[62:0], a[k]};
      if (r >= b) begin
        r    = r - b;
        q[k] = 1'b1;
      end
    end
    return q;
  endfunction

  // exp(-f) for f in Q.30 by a truncated alternating series.
  function automatic longint unsigned exp_neg_frac(input longint unsigned f);
    longint unsigned t;
    longint unsigned s;
    t = Q30_ONE;
    s = Q30_ONE;
    for (int j = 1; j <= SERIES_TERMS; j++) begin
      t = udiv((t * f) >> 30, longint'(j));
      if ((j & 1) == 1) s = s - t;
      else              s = s + t;
    end
    return s;
  endfunction

  // One table sample of the standard normal density, unsigned Q0.32.
  function automatic logic [31:0] rom_entry(input int idx, input int points,
                                            input int range_std);
    longint unsigned d, den, e1, k, num, n, f, v, i, r;
    d   = longint'(points) - 1;
    den = 2 * d * d;
    e1  = exp_neg_frac(Q30_ONE);
    i   = longint'(idx);
    r   = longint'(range_std);
    k   = (2 * i > d) ? 2 * i - d : d - 2 * i;
    num = r * r * k * k;
    n   = udiv(num, den);
    f   = udiv((num - n * den) << 30, den);
    if (n >= EXP_CUTOFF) return 32'd0;
    v = exp_neg_frac(f);
    for (longint unsigned m = 0; m < n; m++) v = (v * e1) >> 30;
    v = (v * INV_SQRT_2PI) >> 30;
    return v[31:0];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/glk_ram.sv =====
`default_nettype none
module glk_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                                     clk,
  input  wire logic                                     we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  wire logic [WIDTH-1:0]                         wdata,
  output logic      [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single port, read before write (a write returns the old data), registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

// ===== rtl/glk_rom.sv =====
`default_nettype none
module glk_rom #(
  parameter int TABLE_POINTS = glk_pkg::TABLE_POINTS_DEF,
  parameter int STD_RANGE    = glk_pkg::STD_RANGE_DEF
) (
  input  wire logic                            clk,
  input  wire logic [$clog2(TABLE_POINTS)-1:0] addr,
  output logic      [31:0]                     data
);

  logic [31:0] tbl [TABLE_POINTS];

  // Samples are worked out at elaboration.
  for (genvar g = 0; g < TABLE_POINTS; g++) begin : g_ent
    localparam logic [31:0] ENT = glk_pkg::rom_entry(g, TABLE_POINTS, STD_RANGE);
    assign tbl[g] = ENT;
  end

  // Registered read.
  always_ff @(posedge clk) begin
    data <= tbl[addr];
  end

endmodule
`default_nettype wire

// ===== rtl/glk_div.sv =====
`default_nettype none
module glk_div (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire glk_pkg::div_req_t              req,
  input  wire logic [glk_pkg::DVD_W-1:0]      dividend,
  input  wire logic [glk_pkg::DVS_W-1:0]      divisor,
  output logic                                done,
  output logic      [glk_pkg::DVD_W-1:0]      quotient
);

  logic                          run;
  logic [glk_pkg::DCNT_W-1:0]    cnt;
  logic [glk_pkg::DVD_W-1:0]     dvd;
  logic [glk_pkg::DVS_W-1:0]     dvs;
  logic [glk_pkg::DVS_W-1:0]     rem;
  logic [glk_pkg::DVS_W:0]       rem_sh;
  logic                          fits;

  // One restoring step: shift in the next dividend bit and try a subtract.
  assign rem_sh = {rem, dvd[glk_pkg::DVD_W-1]};
  assign fits   = rem_sh >= {1'b0, dvs};

  // Control: runs count steps from the top of the dividend.
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        run <= 1'b1;
        cnt <= req.count;
      end else if (run) begin
        cnt <= cnt - 1'b1;
        if (cnt == glk_pkg::DCNT_W'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd      <= dividend;
      dvs      <= divisor;
      rem      <= '0;
      quotient <= '0;
    end else if (run) begin
      dvd      <= {dvd[glk_pkg::DVD_W-2:0], 1'b0};
      quotient <= {quotient[glk_pkg::DVD_W-2:0], fits};
      if (fits) rem <= glk_pkg::DVS_W'(rem_sh - {1'b0, dvs});
      else      rem <= rem_sh[glk_pkg::DVS_W-1:0];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/gaussian_lut_kernel_generator.sv =====
`default_nettype none
// Gaussian density and normalized kernel generator. Pulse start while busy is
// low: func 0 returns one Q8.24 value pdf((x_in-mean)*sigma_recip)*sigma_recip,
// func 1 returns num_taps normalized taps in order, the last one marked, with
// num_taps clamped to 1..MAX_TAPS. Each result is shown for exactly one cycle
// with result_valid high and cannot be held off, so the receiver must take it
// then. busy rises in the cycle after start is taken and falls in the cycle in
// which the final result is shown. One evaluation is a sequence of states
// around a single shared multiplier (cut short after the range check when the
// standardized argument lies outside the table), the table bin being split by
// a reciprocal multiplication. A kernel evaluates every tap, takes the
// reciprocal of the tap sum from the bit-serial divider (skipped when the sum
// is zero) and then normalizes the taps in turn through S_NRM_RD, S_NRM_M1,
// S_NRM_M2 and S_NRM_ADD. The shared multiplier and the one-bit-per-cycle
// divider set the run time.
module gaussian_lut_kernel_generator #(
  parameter int MAX_TAPS     = glk_pkg::MAX_TAPS_DEF,
  parameter int TABLE_POINTS = glk_pkg::TABLE_POINTS_DEF,
  parameter int STD_RANGE    = glk_pkg::STD_RANGE_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic                               func,
  input  wire logic signed [glk_pkg::X_W-1:0]     x_in,
  input  wire logic signed [glk_pkg::X_W-1:0]     mean,
  input  wire logic        [glk_pkg::INV_W-1:0]   sigma_recip,
  input  wire logic        [glk_pkg::NT_W-1:0]    num_taps,
  output logic                                    result_valid,
  output logic             [glk_pkg::VAL_W-1:0]   value_out,
  output logic             [glk_pkg::TIDX_W-1:0]  tap_index,
  output logic                                    last
);

  localparam int TP_W  = $clog2(TABLE_POINTS);
  localparam int TI_W  = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int CNT_W = $clog2(MAX_TAPS + 1);
  localparam int U_W   = $clog2(STD_RANGE) + 33;
  localparam int QN_W  = U_W + TP_W - 17;
  localparam int Q_W   = TP_W + 16;
  localparam logic [U_W-1:0]  LIM   = U_W'(STD_RANGE) << 32;
  localparam logic [TP_W-1:0] D_PTS = TP_W'(TABLE_POINTS - 1);
  localparam logic [TP_W-1:0] IDX_MAX = TP_W'(TABLE_POINTS - 2);

  // Reciprocal of the range, exact for every bin numerator below 2^QN_W.
  localparam int S_CLG = $clog2(STD_RANGE);
  localparam int QK    = QN_W + S_CLG;
  localparam longint unsigned QRECIP =
    ((64'd1 << QK) + 64'(STD_RANGE) - 64'd1) / 64'(STD_RANGE);
  localparam logic [glk_pkg::MB_W-1:0] QR_LO = glk_pkg::MB_W'(QRECIP);
  localparam logic [glk_pkg::MB_W-1:0] QR_HI = glk_pkg::MB_W'(QRECIP >> 32);
  localparam int QF_W  = glk_pkg::MP_W + 33;

  typedef enum logic [20:0] {
    S_IDLE    = 21'h000001,
    S_PREP    = 21'h000002,
    S_MUL_A   = 21'h000004,
    S_CHK     = 21'h000008,
    S_MUL_U   = 21'h000010,
    S_QLO     = 21'h000020,
    S_QHI     = 21'h000040,
    S_QSUM    = 21'h000080,
    S_ROM_LO  = 21'h000100,
    S_ROM_HI  = 21'h000200,
    S_MUL_LO  = 21'h000400,
    S_MUL_HI  = 21'h000800,
    S_SUM     = 21'h001000,
    S_MUL_V   = 21'h002000,
    S_TAP     = 21'h004000,
    S_RECIP   = 21'h008000,
    S_WAITR   = 21'h010000,
    S_NRM_RD  = 21'h020000,
    S_NRM_M1  = 21'h040000,
    S_NRM_M2  = 21'h080000,
    S_NRM_ADD = 21'h100000
  } state_t;

  state_t state, state_next;

  logic                              func_r;
  logic [glk_pkg::INV_W-1:0]         inv;
  logic [glk_pkg::ABS_W-1:0]         absd;
  logic [CNT_W-1:0]                  n;
  logic [CNT_W-1:0]                  i;
  logic                              zero_f;
  logic [U_W-1:0]                    u;
  logic [QN_W-1:0]                   nq;
  logic [glk_pkg::MP_W-1:0]          plo;
  logic [Q_W-1:0]                    qv;
  logic [31:0]                       lo;
  logic [31:0]                       hi;
  logic [48:0]                       acc;
  logic [31:0]                       vreg;
  logic [31:0]                       tapr;
  logic [31:0]                       p1hi;
  logic [39:0]                       sum;
  logic [glk_pkg::DVD_W-1:0]         recip;
  logic [glk_pkg::MP_W-1:0]          prod;
  logic [glk_pkg::MA_W-1:0]          mul_a;
  logic [glk_pkg::MB_W-1:0]          mul_b;

  logic signed [glk_pkg::ABS_W-1:0]  dd;
  logic [glk_pkg::ABS_W-1:0]         absd_in;
  logic [CNT_W-1:0]                  n_in;
  logic [CNT_W:0]                    two_i;
  logic [CNT_W:0]                    nm1;
  logic [CNT_W:0]                    pos;
  logic [QF_W-1:0]                   qfull;
  logic [TP_W-1:0]                   idx_c;
  logic [TP_W-1:0]                   rom_addr;
  logic [31:0]                       rom_q;
  logic [15:0]                       fr;
  logic [31:0]                       tap_val;
  logic                              last_tap;
  logic [63:0]                       nrm_t;
  logic                              ram_we;
  logic [31:0]                       ram_q;
  glk_pkg::div_req_t                 dreq;
  logic [glk_pkg::DVD_W-1:0]         div_dvd;
  logic [glk_pkg::DVS_W-1:0]         div_dvs;
  logic                              div_done;
  logic [glk_pkg::DVD_W-1:0]         div_quo;

  assign busy = (state != S_IDLE);

  // Request decode: |x - mean| and the clamped tap count.
  assign dd      = glk_pkg::ABS_W'(x_in) - glk_pkg::ABS_W'(mean);
  assign absd_in = dd[glk_pkg::ABS_W-1] ? glk_pkg::ABS_W'(-dd) : glk_pkg::ABS_W'(dd);
  always_comb begin
    if (num_taps == '0)                 n_in = CNT_W'(1);
    else if (int'(num_taps) > MAX_TAPS) n_in = CNT_W'(MAX_TAPS);
    else                                n_in = CNT_W'(num_taps);
  end

  // Tap position in half units, |2i - (n-1)|.
  assign two_i = {i, 1'b0};
  assign nm1   = {1'b0, n - 1'b1};
  assign pos   = (two_i >= nm1) ? two_i - nm1 : nm1 - two_i;
  assign last_tap = (i == n - 1'b1);

  // Bin position: the numerator times the reciprocal of the range, in two halves.
  assign qfull = QF_W'({prod, 32'd0}) + QF_W'(plo);

  // Bin index and fraction, index clamped to the last interval.
  assign idx_c    = (qv[Q_W-1:16] > IDX_MAX) ? IDX_MAX : qv[Q_W-1:16];
  assign fr       = qv[15:0];
  assign rom_addr = (state == S_ROM_HI) ? idx_c + 1'b1 : idx_c;

  assign tap_val = zero_f ? 32'd0 : prod[55:24];
  assign nrm_t   = {1'b0, prod[62:0]} + {32'd0, p1hi};

  // Shared multiplier operand selection, product registered.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_MUL_A:  begin mul_a = glk_pkg::MA_W'(absd); mul_b = glk_pkg::MB_W'(inv); end
      S_MUL_U:  begin mul_a = glk_pkg::MA_W'(u);    mul_b = glk_pkg::MB_W'(D_PTS); end
      S_QLO: begin
        mul_a = glk_pkg::MA_W'(prod[U_W+TP_W-1:17]);
        mul_b = QR_LO;
      end
      S_QHI:    begin mul_a = glk_pkg::MA_W'(nq);   mul_b = QR_HI; end
      S_MUL_LO: begin
        mul_a = glk_pkg::MA_W'(lo);
        mul_b = glk_pkg::MB_W'(17'h10000 - {1'b0, fr});
      end
      S_MUL_HI: begin mul_a = glk_pkg::MA_W'(hi);   mul_b = glk_pkg::MB_W'(fr); end
      S_MUL_V:  begin mul_a = glk_pkg::MA_W'(vreg); mul_b = glk_pkg::MB_W'(inv); end
      S_NRM_M1: begin mul_a = glk_pkg::MA_W'(ram_q); mul_b = recip[31:0]; end
      S_NRM_M2: begin
        mul_a = glk_pkg::MA_W'(tapr);
        mul_b = glk_pkg::MB_W'(recip[glk_pkg::DVD_W-1:32]);
      end
      default: begin end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= glk_pkg::MP_W'(mul_a) * glk_pkg::MP_W'(mul_b);
  end

  // Divider request: the reciprocal of a non-zero tap sum.
  always_comb begin
    dreq    = '0;
    div_dvd = '0;
    div_dvs = '0;
    if (state == S_RECIP && sum != '0) begin
      dreq.start = 1'b1;
      dreq.count = glk_pkg::DCNT_W'(glk_pkg::DVD_W);
      div_dvd    = glk_pkg::DVD_W'(1) << 62;
      div_dvs    = sum;
    end
  end

  // Sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:    if (start) state_next = S_PREP;
      S_PREP:    state_next = S_MUL_A;
      S_MUL_A:   state_next = S_CHK;
      S_CHK:     state_next = (prod > glk_pkg::MP_W'(LIM)) ? S_TAP : S_MUL_U;
      S_MUL_U:   state_next = S_QLO;
      S_QLO:     state_next = S_QHI;
      S_QHI:     state_next = S_QSUM;
      S_QSUM:    state_next = S_ROM_LO;
      S_ROM_LO:  state_next = S_ROM_HI;
      S_ROM_HI:  state_next = S_MUL_LO;
      S_MUL_LO:  state_next = S_MUL_HI;
      S_MUL_HI:  state_next = S_SUM;
      S_SUM:     state_next = S_MUL_V;
      S_MUL_V:   state_next = S_TAP;
      S_TAP: begin
        if (!func_r)       state_next = S_IDLE;
        else if (last_tap) state_next = S_RECIP;
        else               state_next = S_PREP;
      end
      S_RECIP:   state_next = (sum != '0) ? S_WAITR : S_NRM_RD;
      S_WAITR:   if (div_done) state_next = S_NRM_RD;
      S_NRM_RD:  state_next = S_NRM_M1;
      S_NRM_M1:  state_next = S_NRM_M2;
      S_NRM_M2:  state_next = S_NRM_ADD;
      S_NRM_ADD: state_next = last_tap ? S_IDLE : S_NRM_RD;
      default:   state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // Control registers and result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      i            <= '0;
      sum          <= '0;
    end else begin
      result_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (start) begin
          i   <= '0;
          sum <= '0;
        end
        S_TAP: if (func_r) begin
          sum <= sum + 40'(tap_val);
          i   <= last_tap ? '0 : i + 1'b1;
        end else begin
          result_valid <= 1'b1;
        end
        S_NRM_ADD: begin
          result_valid <= 1'b1;
          i            <= i + 1'b1;
        end
        default: begin end
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: if (start) begin
        func_r <= func;
        inv    <= sigma_recip;
        absd   <= absd_in;
        n      <= n_in;
      end
      S_PREP: begin
        zero_f <= 1'b0;
        if (func_r) absd <= glk_pkg::ABS_W'({pos, 15'd0});
      end
      S_CHK: begin
        if (prod > glk_pkg::MP_W'(LIM)) zero_f <= 1'b1;
        u <= LIM - prod[U_W-1:0];
      end
      S_QLO:    nq <= prod[U_W+TP_W-1:17];
      S_QHI:    plo <= prod;
      S_QSUM:   qv <= qfull[QK +: Q_W];
      S_ROM_HI: lo <= rom_q;
      S_MUL_LO: hi <= rom_q;
      S_MUL_HI: acc <= prod[48:0];
      S_SUM:    vreg <= 32'((49'(acc) + prod[48:0]) >> 16);
      S_TAP: if (!func_r) begin
        value_out <= tap_val;
        tap_index <= '0;
        last      <= 1'b1;
      end
      S_RECIP:  recip <= '0;
      S_WAITR:  if (div_done) recip <= div_quo;
      S_NRM_M1: tapr <= ram_q;
      S_NRM_M2: p1hi <= prod[63:32];
      S_NRM_ADD: begin
        value_out <= (sum == '0) ? 32'd0 : nrm_t[37:6];
        tap_index <= glk_pkg::TIDX_W'(i);
        last      <= last_tap;
      end
      default: begin end
    endcase
  end

  assign ram_we = (state == S_TAP) && func_r;

  glk_rom #(
    .TABLE_POINTS (TABLE_POINTS),
    .STD_RANGE    (STD_RANGE)
  ) u_rom (
    .clk  (clk),
    .addr (rom_addr),
    .data (rom_q)
  );

  glk_ram #(
    .WIDTH (32),
    .DEPTH (MAX_TAPS)
  ) u_taps (
    .clk   (clk),
    .we    (ram_we),
    .addr  (i[TI_W-1:0]),
    .wdata (tap_val),
    .rdata (ram_q)
  );

  glk_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (dreq),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_quo)
  );

  // A result only ever comes out of a request in progress.
  a_valid_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(busy))
    else $error("result without a request in progress");

  // The final result of a request ends it.
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    result_valid && last |-> !busy)
    else $error("still busy after the final result");

  // More results follow an unmarked one.
  a_more: assert property (@(posedge clk) disable iff (rst)
    result_valid && !last |-> busy)
    else $error("request ended without a final result");

  // An accepted item starts work.
  a_start: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("item accepted but not started");

endmodule
`default_nettype wire
